// File: rtl/pti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types, codes and constants of the profile table interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

  // operation field codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_LINEAR  = 2'd1;
  localparam logic [1:0] OP_ANGULAR = 2'd2;

  // command kinds after classification
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_LINEAR  = 2'd1;
  localparam logic [1:0] CMD_ANGULAR = 2'd2;

  // result source codes
  localparam logic [2:0] SRC_FALLBACK = 3'd0;
  localparam logic [2:0] SRC_FIRST    = 3'd1;
  localparam logic [2:0] SRC_INTERP   = 3'd2;
  localparam logic [2:0] SRC_ZSPAN    = 3'd3;
  localparam logic [2:0] SRC_LAST     = 3'd4;
  localparam logic [2:0] SRC_WRITE    = 3'd5;

  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;

  // angles in degrees, Q16.16
  localparam logic signed [37:0] DEG_FULL    = 38'sd23592960;
  localparam logic signed [37:0] DEG_HALF    = 38'sd11796480;
  localparam logic signed [37:0] DEG_QUARTER = 38'sd5898240;
  localparam logic signed [37:0] DEG_3QUART  = 38'sd17694720;
  localparam logic signed [37:0] CORDIC_GAIN = 38'sd652032874;
  localparam int CORDIC_STEPS = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         index;
    logic signed [23:0] altitude;
    logic signed [31:0] value;
    logic signed [23:0] target;
    logic signed [31:0] fallback;
    logic [4:0]         level_count;
  } pti_cmd_t;

  function automatic logic signed [37:0] atan_deg(input logic [3:0] k);
    logic signed [37:0] a;
    unique case (k)
      4'd0:    a = 38'sd2949120;
      4'd1:    a = 38'sd1740967;
      4'd2:    a = 38'sd919879;
      4'd3:    a = 38'sd466945;
      4'd4:    a = 38'sd234379;
      4'd5:    a = 38'sd117304;
      4'd6:    a = 38'sd58666;
      4'd7:    a = 38'sd29335;
      4'd8:    a = 38'sd14668;
      4'd9:    a = 38'sd7334;
      4'd10:   a = 38'sd3667;
      4'd11:   a = 38'sd1833;
      4'd12:   a = 38'sd917;
      4'd13:   a = 38'sd458;
      4'd14:   a = 38'sd229;
      default: a = 38'sd115;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/pti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_front
// Takes items in, holds the level count register and classifies each item
// into a command for the queue.
// ----------------------------------------------------------------------------
module pti_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [3:0]         entry_index,
  input  logic signed [23:0] entry_altitude,
  input  logic signed [31:0] entry_value,
  input  logic signed [23:0] target_altitude,
  input  logic signed [31:0] fallback_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output pti_pkg::pti_cmd_t  cmd
);
  import pti_pkg::*;

  logic [4:0] level_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= '0;
    end else if (cfg_we) begin
      level_count <= cfg_data;
    end
  end

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    unique case (operation)
      OP_WRITE:   cmd.kind = CMD_WRITE;
      OP_ANGULAR: cmd.kind = CMD_ANGULAR;
      default:    cmd.kind = CMD_LINEAR; // unused code runs as linear
    endcase
    cmd.index       = entry_index;
    cmd.altitude    = entry_altitude;
    cmd.value       = entry_value;
    cmd.target      = target_altitude;
    cmd.fallback    = fallback_value;
    cmd.level_count = level_count;
  end

endmodule

// File: rtl/pti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pti_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pti_pkg::pti_cmd_t push_cmd,
  input  logic              pop,
  output pti_pkg::pti_cmd_t pop_cmd,
  output logic              full,
  output logic              empty
);
  import pti_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  pti_cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count did not rise on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - (PW+1)'(1))
    else $error("queue count did not fall on pop");

endmodule

// File: rtl/pti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pti_back
// Command engine: table store, breakpoint search, ratio divider, shared
// multiplier and a shared CORDIC for the angular blend.
// ----------------------------------------------------------------------------
module pti_back #(
  parameter int LEVELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  pti_pkg::pti_cmd_t  q_cmd,
  output logic               q_pop,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [2:0]         result_source
);
  import pti_pkg::*;

  localparam int IW = $clog2(LEVELS);
  localparam int NW = $clog2(LEVELS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_WAIT0 = 4'd2;
  localparam logic [3:0] ST_FIRST = 4'd3;
  localparam logic [3:0] ST_WAIT  = 4'd4;
  localparam logic [3:0] ST_CHK   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_POST  = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_LIN   = 4'd9;
  localparam logic [3:0] ST_MOD   = 4'd10;
  localparam logic [3:0] ST_ROT   = 4'd11;
  localparam logic [3:0] ST_BLEND = 4'd12;
  localparam logic [3:0] ST_VSET  = 4'd13;
  localparam logic [3:0] ST_VEC   = 4'd14;
  localparam logic [3:0] ST_VFIN  = 4'd15;

  logic [3:0]         state;
  pti_cmd_t           cmd;
  logic [IW-1:0]      idx;
  logic [3:0]         cnt;
  logic               sel;
  logic               neg;

  logic signed [23:0] alt_mem [LEVELS];
  logic signed [31:0] val_mem [LEVELS];
  logic signed [23:0] rd_alt;
  logic signed [31:0] rd_val;

  logic signed [23:0] prev_alt;
  logic signed [31:0] prev_val;
  logic signed [31:0] val_hi;
  logic signed [24:0] span;
  logic [24:0]        rem;
  logic [16:0]        ratio;

  logic signed [37:0] ang;
  logic signed [37:0] x;
  logic signed [37:0] y;
  logic signed [37:0] z;
  logic signed [37:0] base;
  logic signed [37:0] c0, s0, c1, s1;
  logic signed [55:0] prod;
  logic signed [57:0] acc_s;
  logic signed [57:0] acc_c;

  // combinational helpers
  logic               mem_we;
  logic [NW-1:0]      n_lv;
  logic signed [24:0] span_c;
  logic signed [24:0] num_c;
  logic               le_c;
  logic [25:0]        rem2;
  logic               q_bit;
  logic signed [37:0] dk;
  logic signed [37:0] ang_sub;
  logic signed [37:0] xs, ys;
  logic signed [37:0] rot_x, rot_y, rot_a;
  logic signed [37:0] vec_x, vec_y, vec_z;
  logic signed [37:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [17:0] w_lo;
  logic signed [17:0] w_hi;
  logic signed [37:0] bl_s;
  logic signed [37:0] bl_c;
  logic signed [37:0] fin_a;
  logic signed [33:0] lin_v;

  function automatic logic signed [37:0] ang_load(input logic signed [31:0] v);
    logic signed [37:0] e;
    e = 38'(v);
    // negative angles lifted by 128 turns so the reduction sees a positive value
    return (v < 0) ? e + (DEG_FULL <<< 7) : e;
  endfunction

  assign mem_we = (state == ST_START) && (cmd.kind == CMD_WRITE)
                  && (int'(cmd.index) < LEVELS);
  assign n_lv   = (int'(cmd.level_count) >= LEVELS) ? NW'(LEVELS) : NW'(cmd.level_count);
  assign q_pop  = (state == ST_IDLE) && !q_empty;

  assign span_c = 25'(rd_alt) - 25'(prev_alt);
  assign num_c  = 25'($signed(cmd.target)) - 25'(prev_alt);
  assign le_c   = $signed(cmd.target) <= rd_alt;

  assign rem2   = {rem, 1'b0};
  assign q_bit  = rem2 >= {1'b0, span[24:0]};

  assign dk      = DEG_FULL <<< cnt[2:0];
  assign ang_sub = (ang >= dk) ? ang - dk : ang;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;

  always_comb begin
    if (ang >= 0) begin
      rot_x = x - ys;
      rot_y = y + xs;
      rot_a = ang - atan_deg(cnt);
    end else begin
      rot_x = x + ys;
      rot_y = y - xs;
      rot_a = ang + atan_deg(cnt);
    end
    if (y >= 0) begin
      vec_x = x + ys;
      vec_y = y - xs;
      vec_z = z + atan_deg(cnt);
    end else begin
      vec_x = x - ys;
      vec_y = y + xs;
      vec_z = z - atan_deg(cnt);
    end
  end

  assign w_hi = 18'(ratio);
  assign w_lo = 18'(17'd65536 - ratio);

  always_comb begin
    mul_a = 38'(val_hi) - 38'(prev_val);
    mul_b = w_hi;
    if (state == ST_BLEND) begin
      unique case (cnt[1:0])
        2'd0: begin mul_a = s0; mul_b = w_lo; end
        2'd1: begin mul_a = s1; mul_b = w_hi; end
        2'd2: begin mul_a = c0; mul_b = w_lo; end
        default: begin mul_a = c1; mul_b = w_hi; end
      endcase
    end
  end

  assign bl_s  = 38'(acc_s >>> 16);
  assign bl_c  = 38'(acc_c >>> 16);
  assign fin_a = base + z;
  assign lin_v = 34'(prev_val) + 34'((prod + 56'sd32768) >>> 16);

  // table store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      alt_mem[IW'(cmd.index)] <= cmd.altitude;
      val_mem[IW'(cmd.index)] <= cmd.value;
    end
    rd_alt <= alt_mem[idx];
    rd_val <= val_mem[idx];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_cmd;
            state <= ST_START;
          end
        end
        ST_START: begin
          idx <= '0;
          if (cmd.kind == CMD_WRITE) begin
            done          <= 1'b1;
            result_value  <= '0;
            result_source <= SRC_WRITE;
            state         <= ST_IDLE;
          end else if (n_lv == '0) begin
            done          <= 1'b1;
            result_value  <= cmd.fallback;
            result_source <= SRC_FALLBACK;
            state         <= ST_IDLE;
          end else begin
            state <= ST_WAIT0;
          end
        end
        ST_WAIT0: state <= ST_FIRST;
        ST_FIRST: begin
          prev_alt <= rd_alt;
          prev_val <= rd_val;
          if (n_lv == NW'(1) || le_c) begin
            done          <= 1'b1;
            result_value  <= rd_val;
            result_source <= SRC_FIRST;
            state         <= ST_IDLE;
          end else begin
            idx   <= IW'(1);
            state <= ST_WAIT;
          end
        end
        ST_WAIT: state <= ST_CHK;
        ST_CHK: begin
          if (le_c) begin
            val_hi <= rd_val;
            span   <= span_c;
            rem    <= num_c;
            cnt    <= '0;
            if (span_c == '0) begin
              done          <= 1'b1;
              result_value  <= rd_val;
              result_source <= SRC_ZSPAN;
              state         <= ST_IDLE;
            end else if (num_c <= 0) begin
              ratio <= '0;
              state <= ST_POST;
            end else if (span_c < 0 || num_c >= span_c) begin
              ratio <= 17'd65536;
              state <= ST_POST;
            end else begin
              ratio <= '0;
              state <= ST_DIV;
            end
          end else if (NW'(idx) + NW'(1) == n_lv) begin
            done          <= 1'b1;
            result_value  <= rd_val;
            result_source <= SRC_LAST;
            state         <= ST_IDLE;
          end else begin
            prev_alt <= rd_alt;
            prev_val <= rd_val;
            idx      <= idx + IW'(1);
            state    <= ST_WAIT;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle; num < span here
          rem   <= q_bit ? 25'(rem2 - {1'b0, span[24:0]}) : rem2[24:0];
          ratio <= {ratio[15:0], q_bit};
          cnt   <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (cmd.kind == CMD_ANGULAR) begin
            sel   <= 1'b0;
            ang   <= ang_load(prev_val);
            cnt   <= 4'd7;
            state <= ST_MOD;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_LIN;
        ST_LIN: begin
          done          <= 1'b1;
          result_value  <= 32'(lin_v);
          result_source <= SRC_INTERP;
          state         <= ST_IDLE;
        end
        ST_MOD: begin
          // binary reduction modulo a full turn, then fold into +/- a quarter
          if (cnt == 4'd0) begin
            x   <= CORDIC_GAIN;
            y   <= '0;
            neg <= 1'b0;
            if (ang_sub > DEG_QUARTER && ang_sub < DEG_3QUART) begin
              ang <= ang_sub - DEG_HALF;
              neg <= 1'b1;
            end else if (ang_sub >= DEG_3QUART) begin
              ang <= ang_sub - DEG_FULL;
            end else begin
              ang <= ang_sub;
            end
            state <= ST_ROT;
          end else begin
            ang <= ang_sub;
            cnt <= cnt - 4'd1;
          end
        end
        ST_ROT: begin
          x   <= rot_x;
          y   <= rot_y;
          ang <= rot_a;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(CORDIC_STEPS - 1)) begin
            if (!sel) begin
              c0    <= neg ? -rot_x : rot_x;
              s0    <= neg ? -rot_y : rot_y;
              sel   <= 1'b1;
              ang   <= ang_load(val_hi);
              cnt   <= 4'd7;
              state <= ST_MOD;
            end else begin
              c1    <= neg ? -rot_x : rot_x;
              s1    <= neg ? -rot_y : rot_y;
              cnt   <= '0;
              state <= ST_BLEND;
            end
          end
        end
        ST_BLEND: begin
          // one product a cycle, each summed from the registered product in the cycle after its operands are selected
          cnt <= cnt + 4'd1;
          priority case (cnt)
            4'd1: acc_s <= 58'(prod);
            4'd2: acc_s <= acc_s + 58'(prod);
            4'd3: acc_c <= 58'(prod);
            4'd4: begin
              acc_c <= acc_c + 58'(prod);
              state <= ST_VSET;
            end
            default: ;
          endcase
        end
        ST_VSET: begin
          z   <= '0;
          cnt <= '0;
          if (bl_s == '0) begin
            done          <= 1'b1;
            result_value  <= (bl_c >= 0) ? 32'd0 : 32'(DEG_HALF);
            result_source <= SRC_INTERP;
            state         <= ST_IDLE;
          end else if (bl_c < 0) begin
            x     <= -bl_c;
            y     <= -bl_s;
            base  <= DEG_HALF;
            state <= ST_VEC;
          end else begin
            x     <= bl_c;
            y     <= bl_s;
            base  <= '0;
            state <= ST_VEC;
          end
        end
        ST_VEC: begin
          x   <= vec_x;
          y   <= vec_y;
          z   <= vec_z;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(CORDIC_STEPS - 1)) begin
            state <= ST_VFIN;
          end
        end
        ST_VFIN: begin
          done          <= 1'b1;
          result_source <= SRC_INTERP;
          if (fin_a < 0) begin
            result_value <= 32'(fin_a + DEG_FULL);
          end else if (fin_a >= DEG_FULL) begin
            result_value <= 32'(fin_a - DEG_FULL);
          end else begin
            result_value <= 32'(fin_a);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result shown while engine still busy");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    done && result_source == SRC_WRITE |-> result_value == 32'd0)
    else $error("write transfer carries a non-zero value");

  a_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_POST |-> ratio <= 17'd65536)
    else $error("blend ratio above one");

  a_vec_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_VFIN |=> done && result_source == SRC_INTERP)
    else $error("angular result not delivered");

endmodule

// File: rtl/profile_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_table_interpolator
// Piecewise linear lookup over a table of altitude and value breakpoints,
// with a linear and an angular blend.
// ----------------------------------------------------------------------------
// Flow: a write or fallback ends in the engine's start state; else the first
//   entry is read, then further breakpoints are checked in turn; a blend runs
//   the ratio divider where it runs, then the multiplier (linear) or CORDIC
//   rotation, blend and vectoring (angular). One item at a time in the engine;
//   a 2-entry queue takes start while busy is low; the receiver cannot stall.
// Reset: rst clears level_count, the queue and the engine; tables keep contents.
module profile_table_interpolator #(
  parameter int LEVELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         entry_index,
  input  logic signed [23:0] entry_altitude,
  input  logic signed [31:0] entry_value,
  input  logic signed [23:0] target_altitude,
  input  logic signed [31:0] fallback_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [2:0]         result_source
);
  import pti_pkg::*;

  pti_cmd_t push_cmd;
  pti_cmd_t pop_cmd;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  pti_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .operation       (operation),
    .entry_index     (entry_index),
    .entry_altitude  (entry_altitude),
    .entry_value     (entry_value),
    .target_altitude (target_altitude),
    .fallback_value  (fallback_value),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .cmd             (push_cmd)
  );

  pti_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  pti_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (pop),
    .done          (done),
    .result_value  (result_value),
    .result_source (result_source)
  );

endmodule
